[hdl/assert_macros.svh]
// assertion macros shared by the dispatch modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every clock edge outside reset
`define EGD_CHECK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// condition in one cycle implies a condition in the next
`define EGD_CHECK_NEXT(lbl, cond, nxt, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (nxt)) else $error(msg);

`endif

[hdl/egd_pkg.sv]
// shared types and constants of the elevator group dispatcher
package egd_pkg;

  localparam int DEF_FLOORS = 32;
  localparam int DEF_CARS   = 4;

  localparam logic [1:0] MODE_TICK = 2'd0;
  localparam logic [1:0] MODE_HALL = 2'd1;
  localparam logic [1:0] MODE_CAR  = 2'd2;

  localparam logic [1:0] HD_STOP = 2'd0;
  localparam logic [1:0] HD_UP   = 2'd1;
  localparam logic [1:0] HD_DOWN = 2'd2;

  localparam logic [1:0] CFG_DOOR = 2'd0;
  localparam logic [1:0] CFG_TOP  = 2'd1;

  localparam logic [3:0] DOOR_RESET = 4'd3;
  localparam logic [4:0] TOP_RESET  = 5'd19;

  typedef struct packed {
    logic [1:0] mode;
    logic [4:0] floor;
    logic       hall_dir;
    logic [2:0] car;
  } cmd_t;

  typedef struct packed {
    logic [2:0]  car_index;
    logic [4:0]  car_floor;
    logic [1:0]  car_dir;
    logic [3:0]  loading;
    logic [3:0]  unloading;
    logic [31:0] dest_bits;
    logic [31:0] up_calls;
    logic [31:0] down_calls;
    logic        last_car;
  } status_t;

  typedef struct packed {
    logic [1:0] h_adj;
    logic       at_dest;
    logic       up_here;
    logic       dn_here;
    logic       da;
    logic       db;
    logic       ra;
    logic       rb;
    logic [5:0] cnt_a;
    logic [5:0] cnt_b;
    logic [4:0] near_hi;
    logic [4:0] near_lo;
  } scan_t;

endpackage

[hdl/egd_front.sv]
// input side: accepts items, drops unused modes, queues commands for the sequencer
module egd_front import egd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [1:0] mode,
  input  logic [4:0] floor,
  input  logic       hall_dir,
  input  logic [2:0] car,
  output logic       cmd_valid,
  output cmd_t       cmd,
  input  logic       cmd_pop
);

  cmd_t       mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       keep;
  logic       wr_en;
  logic       rd_en;

  // classify the mode, unused codes carry no work
  always_comb begin
    unique case (mode) inside
      MODE_TICK, MODE_HALL, MODE_CAR: keep = 1'b1;
      default: keep = 1'b0;
    endcase
  end

  assign full      = (count == 2'd2);
  assign wr_en     = push && !full && keep;
  assign rd_en     = cmd_pop && (count != 2'd0);
  assign cmd_valid = (count != 2'd0);
  assign cmd       = mem[rd_ptr];

  // queue pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (wr_en) wr_ptr <= ~wr_ptr;
      if (rd_en) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, wr_en} - {1'b0, rd_en};
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= '{mode: mode, floor: floor, hall_dir: hall_dir, car: car};
    end
  end

endmodule

[hdl/egd_scan.sv]
// floor scan for one car: destinations and calls above and below, nearest calls
module egd_scan import egd_pkg::*; (
  input  logic [4:0]  top,
  input  logic [4:0]  pos,
  input  logic [1:0]  head,
  input  logic [31:0] dst_map,
  input  logic [31:0] up_map,
  input  logic [31:0] dn_map,
  output scan_t       sc
);

  logic [31:0] m;
  logic [31:0] above;
  logic [31:0] below;
  logic [31:0] dst;
  logic [31:0] calls;
  logic [31:0] ca;
  logic [31:0] cb;

  always_comb begin
    m     = (top == 5'd31) ? '1 : ((32'd2 << top) - 32'd1);
    above = ~((32'd2 << pos) - 32'd1);
    below = (32'd1 << pos) - 32'd1;
    dst   = dst_map & m;
    calls = (up_map | dn_map) & m;
    ca    = calls & above;
    cb    = calls & below;

    // stop at the ends
    sc.h_adj = head;
    if ((pos >= top && head == HD_UP) || (pos == 5'd0 && head == HD_DOWN)) begin
      sc.h_adj = HD_STOP;
    end

    sc.at_dest = dst[pos];
    sc.up_here = up_map[pos] & m[pos];
    sc.dn_here = dn_map[pos] & m[pos];
    sc.da      = |(dst & above);
    sc.db      = |(dst & below);
    sc.ra      = |ca;
    sc.rb      = |cb;
    sc.cnt_a   = 6'($countones(ca));
    sc.cnt_b   = 6'($countones(cb));

    // nearest call above is the lowest bit set, below the highest
    sc.near_hi = 5'd0;
    for (int i = 31; i >= 0; i--) begin
      if (ca[i]) sc.near_hi = 5'(i);
    end
    sc.near_lo = 5'd0;
    for (int i = 0; i < 32; i++) begin
      if (cb[i]) sc.near_lo = 5'(i);
    end
  end

endmodule

[hdl/egd_outq.sv]
// result side: two-entry queue of car status records
`include "assert_macros.svh"
module egd_outq import egd_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    st_push,
  output logic    st_full,
  input  status_t st_in,
  output logic    empty,
  input  logic    pop,
  output status_t st_out
);

  status_t    mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       wr_en;
  logic       rd_en;

  assign st_full = (count == 2'd2);
  assign empty   = (count == 2'd0);
  assign wr_en   = st_push && !st_full;
  assign rd_en   = pop && !empty;
  assign st_out  = mem[rd_ptr];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (wr_en) wr_ptr <= ~wr_ptr;
      if (rd_en) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, wr_en} - {1'b0, rd_en};
    end
  end

  // record storage
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_ptr] <= st_in;
  end

  `EGD_CHECK(a_outq_count, count != 2'd3, "result queue count overflow")
  `EGD_CHECK_NEXT(a_outq_hold, st_full && !pop, st_full, "full queue lost an entry")

endmodule

[hdl/egd_back.sv]
// dispatch sequencer: call maps, car state, per-car decisions, moves and status
`include "assert_macros.svh"
module egd_back import egd_pkg::*; #(
  parameter int CARS = DEF_CARS
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cmd_valid,
  input  cmd_t       cmd,
  output logic       cmd_pop,
  input  logic [3:0] door_time,
  input  logic [4:0] top,
  output logic       st_push,
  input  logic       st_full,
  output status_t    st
);

  localparam int CW = (CARS > 1) ? $clog2(CARS) : 1;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_SCAN   = 5'b00010,
    ST_DECIDE = 5'b00100,
    ST_MOVE   = 5'b01000,
    ST_EMIT   = 5'b10000
  } state_t;

  state_t      state, state_next;
  logic [CW-1:0] cur, cur_next;
  logic [31:0] up_map, up_map_next;
  logic [31:0] dn_map, dn_map_next;
  logic [31:0] dest [CARS];
  logic [31:0] dest_next [CARS];
  logic [4:0]  pos [CARS];
  logic [4:0]  pos_next [CARS];
  logic [1:0]  head [CARS];
  logic [1:0]  head_next [CARS];
  logic [3:0]  ldc [CARS];
  logic [3:0]  ldc_next [CARS];
  logic [3:0]  ulc [CARS];
  logic [3:0]  ulc_next [CARS];
  scan_t       sc, sc_q;

  logic [4:0]  p;
  logic [1:0]  h;
  logic [1:0]  hd_new;
  logic        clr_dest, clr_up, clr_dn, set_ul, set_ld;
  logic        btw_up, btw_dn, opp_up, opp_dn;
  logic [4:0]  n_up, n_dn;
  logic [4:0]  f;
  logic [1:0]  d;
  logic        up_like, dn_like;
  logic        car_ok;

  assign p = pos[cur];
  assign h = sc_q.h_adj;

  egd_scan u_scan (
    .top     (top),
    .pos     (pos[cur]),
    .head    (head[cur]),
    .dst_map (dest[cur]),
    .up_map  (up_map),
    .dn_map  (dn_map),
    .sc      (sc)
  );

  // weigh the other cars and pick this car's action
  always_comb begin
    btw_up = 1'b0;
    btw_dn = 1'b0;
    opp_up = 1'b0;
    opp_dn = 1'b0;
    n_up   = '0;
    n_dn   = '0;
    for (int i = 0; i < CARS; i++) begin
      f       = pos[i];
      d       = head[i];
      up_like = (d == HD_UP) || (d == HD_STOP);
      dn_like = (d == HD_DOWN) || (d == HD_STOP);
      if (CW'(i) != cur) begin
        if (up_like && sc_q.ra) begin
          if ((f > p && f <= sc_q.near_hi) || (f == p && i < int'(cur))) btw_up = 1'b1;
          if (f > p || (f == p && i < int'(cur))) n_up = n_up + 5'd1;
        end
        if (dn_like && sc_q.rb) begin
          if ((f < p && f >= sc_q.near_lo) || (f == p && i < int'(cur))) btw_dn = 1'b1;
          if (f < p || (f == p && i < int'(cur))) n_dn = n_dn + 5'd1;
        end
        if (up_like && sc_q.rb && sc_q.near_lo >= f
            && (sc_q.near_lo - f) < (p - sc_q.near_lo)) begin
          opp_up = 1'b1;
          n_dn   = n_dn + 5'd1;
        end
        if (dn_like && sc_q.ra && f >= sc_q.near_hi
            && (f - sc_q.near_hi) < (sc_q.near_hi - p)) begin
          opp_dn = 1'b1;
          n_up   = n_up + 5'd1;
        end
      end
    end

    hd_new   = h;
    clr_dest = 1'b0;
    clr_up   = 1'b0;
    clr_dn   = 1'b0;
    set_ul   = 1'b0;
    set_ld   = 1'b0;
    if (sc_q.at_dest) begin
      clr_dest = 1'b1;
      set_ul   = 1'b1;
    end else if (sc_q.da && (h == HD_STOP || h == HD_UP)) begin
      hd_new = HD_UP;
    end else if (sc_q.db && (h == HD_STOP || h == HD_DOWN)) begin
      hd_new = HD_DOWN;
    end else if (sc_q.up_here && h != HD_DOWN) begin
      hd_new = HD_UP;
      clr_up = 1'b1;
      set_ld = 1'b1;
    end else if (sc_q.dn_here && h != HD_UP) begin
      hd_new = HD_DOWN;
      clr_dn = 1'b1;
      set_ld = 1'b1;
    end else if (!sc_q.da && !sc_q.ra && !sc_q.db && !sc_q.rb) begin
      hd_new = HD_STOP;
    end else if ((h == HD_UP || h == HD_STOP) && sc_q.ra) begin
      hd_new = HD_UP;
    end else if ((h == HD_UP || h == HD_STOP) && sc_q.rb) begin
      hd_new = HD_DOWN;
    end else if ((h == HD_UP || h == HD_STOP) && sc_q.ra && !btw_up && !opp_dn) begin
      hd_new = HD_UP;
    end else if ((h == HD_DOWN || h == HD_STOP) && sc_q.rb && !btw_dn && !opp_up) begin
      hd_new = HD_DOWN;
    end else if ((h == HD_UP || h == HD_STOP) && sc_q.ra && (btw_up || opp_dn)
                 && {1'b0, n_up} < sc_q.cnt_a) begin
      hd_new = HD_UP;
    end else if ((h == HD_DOWN || h == HD_STOP) && sc_q.rb && (btw_dn || opp_up)
                 && {1'b0, n_dn} < sc_q.cnt_b) begin
      hd_new = HD_DOWN;
    end else begin
      hd_new = HD_STOP;
    end
  end

  assign car_ok  = ({1'b0, cmd.car} < 4'(CARS)) && (cmd.floor <= top);
  assign cmd_pop = (state == ST_IDLE) && cmd_valid;
  assign st_push = (state == ST_EMIT) && !st_full;

  // status record of the current car
  always_comb begin
    st.car_index  = 3'(cur);
    st.car_floor  = pos[cur];
    st.car_dir    = head[cur];
    st.loading    = ldc[cur];
    st.unloading  = ulc[cur];
    st.dest_bits  = dest[cur];
    st.up_calls   = up_map;
    st.down_calls = dn_map;
    st.last_car   = (cur == CW'(CARS - 1));
  end

  // sequencer next state
  always_comb begin
    state_next  = state;
    cur_next    = cur;
    up_map_next = up_map;
    dn_map_next = dn_map;
    dest_next   = dest;
    pos_next    = pos;
    head_next   = head;
    ldc_next    = ldc;
    ulc_next    = ulc;
    unique case (state)
      ST_IDLE: begin
        if (cmd_valid) begin
          case (cmd.mode)
            MODE_HALL: begin
              if (cmd.floor <= top) begin
                if (cmd.hall_dir) dn_map_next[cmd.floor] = 1'b1;
                else up_map_next[cmd.floor] = 1'b1;
              end
            end
            MODE_CAR: begin
              for (int i = 0; i < CARS; i++) begin
                if (car_ok && cmd.car == 3'(i) && cmd.floor != pos[i]) begin
                  dest_next[i][cmd.floor] = 1'b1;
                  if (head[i] == HD_STOP) begin
                    head_next[i] = (cmd.floor < pos[i]) ? HD_DOWN : HD_UP;
                  end
                end
              end
            end
            MODE_TICK: begin
              cur_next   = '0;
              state_next = ST_SCAN;
            end
            default: ;
          endcase
        end
      end
      ST_SCAN: begin
        for (int i = 0; i < CARS; i++) begin
          if (CW'(i) == cur) begin
            if (ldc[i] != 4'd0) ldc_next[i] = ldc[i] - 4'd1;
            if (ulc[i] != 4'd0) ulc_next[i] = ulc[i] - 4'd1;
          end
        end
        state_next = ST_DECIDE;
      end
      ST_DECIDE: begin
        for (int i = 0; i < CARS; i++) begin
          if (CW'(i) == cur) begin
            head_next[i] = hd_new;
            if (clr_dest) dest_next[i][p] = 1'b0;
            if (set_ul && ulc[i] == 4'd0) ulc_next[i] = door_time;
            if (set_ld && ldc[i] == 4'd0) ldc_next[i] = door_time;
          end
        end
        if (clr_up) up_map_next[p] = 1'b0;
        if (clr_dn) dn_map_next[p] = 1'b0;
        if (cur == CW'(CARS - 1)) begin
          state_next = ST_MOVE;
        end else begin
          cur_next   = cur + CW'(1);
          state_next = ST_SCAN;
        end
      end
      ST_MOVE: begin
        for (int i = 0; i < CARS; i++) begin
          if (ldc[i] == 4'd0 && ulc[i] == 4'd0) begin
            if (head[i] == HD_UP && pos[i] < top) pos_next[i] = pos[i] + 5'd1;
            else if (head[i] == HD_DOWN && pos[i] > 5'd0) pos_next[i] = pos[i] - 5'd1;
          end
        end
        cur_next   = '0;
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (!st_full) begin
          if (cur == CW'(CARS - 1)) begin
            state_next = ST_IDLE;
          end else begin
            cur_next = cur + CW'(1);
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      cur    <= '0;
      up_map <= '0;
      dn_map <= '0;
      for (int i = 0; i < CARS; i++) begin
        dest[i] <= '0;
        pos[i]  <= '0;
        head[i] <= HD_STOP;
        ldc[i]  <= '0;
        ulc[i]  <= '0;
      end
    end else begin
      state  <= state_next;
      cur    <= cur_next;
      up_map <= up_map_next;
      dn_map <= dn_map_next;
      dest   <= dest_next;
      pos    <= pos_next;
      head   <= head_next;
      ldc    <= ldc_next;
      ulc    <= ulc_next;
    end
  end

  // scan result register
  always_ff @(posedge clk) begin
    if (state == ST_SCAN) sc_q <= sc;
  end

  `EGD_CHECK(a_push_room, !st_push || !st_full, "status pushed into full queue")
  `EGD_CHECK_NEXT(a_move_emit, state == ST_MOVE, state == ST_EMIT, "move not followed by emit")
  `EGD_CHECK_NEXT(a_tick_scan, cmd_pop && cmd.mode == MODE_TICK, state == ST_SCAN,
    "tick did not start the car walk")

endmodule

[hdl/elevator_group_dispatch_top.sv]
// top level of the elevator group dispatcher
// Calls and ticks enter through a two-entry command queue; the idle sequencer takes a call and
// registers it into the call maps or car destinations. A tick walks the cars one at a time, with
// a floor scan state and then a decision state against the other cars for each car, moves the
// cars together in the move state and then writes one status record per car into a two-entry
// result queue, one per cycle while it has room.
// Configuration writes are always ready and should only be issued while the block is idle.
module elevator_group_dispatch_top import egd_pkg::*; #(
  parameter int FLOORS = DEF_FLOORS,
  parameter int CARS   = DEF_CARS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  mode,
  input  logic [4:0]  floor,
  input  logic        hall_dir,
  input  logic [2:0]  car,
  output logic        empty,
  input  logic        pop,
  output logic [2:0]  car_index,
  output logic [4:0]  car_floor,
  output logic [1:0]  car_dir,
  output logic [3:0]  loading,
  output logic [3:0]  unloading,
  output logic [31:0] dest_bits,
  output logic [31:0] up_calls,
  output logic [31:0] down_calls,
  output logic        last_car,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [4:0]  cfg_data
);

  localparam int TMAX = (FLOORS - 1 > 31) ? 31 : FLOORS - 1;

  logic [3:0] door_time;
  logic [4:0] top_floor;
  logic [4:0] top;
  logic       cmd_valid;
  cmd_t       cmd;
  logic       cmd_pop;
  logic       st_push;
  logic       st_full;
  status_t    st_in;
  status_t    st_out;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      door_time <= DOOR_RESET;
      top_floor <= TOP_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_DOOR: door_time <= cfg_data[3:0];
        CFG_TOP:  top_floor <= cfg_data;
        default: ;
      endcase
    end
  end

  // highest floor in use
  assign top = (top_floor > 5'(TMAX)) ? 5'(TMAX) : top_floor;

  egd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .mode      (mode),
    .floor     (floor),
    .hall_dir  (hall_dir),
    .car       (car),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  egd_back #(.CARS(CARS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .door_time (door_time),
    .top       (top),
    .st_push   (st_push),
    .st_full   (st_full),
    .st        (st_in)
  );

  egd_outq u_outq (
    .clk     (clk),
    .rst     (rst),
    .st_push (st_push),
    .st_full (st_full),
    .st_in   (st_in),
    .empty   (empty),
    .pop     (pop),
    .st_out  (st_out)
  );

  assign car_index  = st_out.car_index;
  assign car_floor  = st_out.car_floor;
  assign car_dir    = st_out.car_dir;
  assign loading    = st_out.loading;
  assign unloading  = st_out.unloading;
  assign dest_bits  = st_out.dest_bits;
  assign up_calls   = st_out.up_calls;
  assign down_calls = st_out.down_calls;
  assign last_car   = st_out.last_car;

endmodule

[tb/sv/elevator_group_dispatch_top_tb.sv]
// testbench for the elevator group dispatcher: predicted car status checked per tick
`timescale 1ns / 100ps

module elevator_group_dispatch_top_tb;
  import egd_pkg::*;

  localparam int NCARS = DEF_CARS;
  localparam int NFLOORS = DEF_FLOORS;
  localparam int MAX_CYCLES = 400000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic        full;
  logic [1:0]  mode = MODE_TICK;
  logic [4:0]  floor = '0;
  logic        hall_dir = 1'b0;
  logic [2:0]  car = '0;
  logic        empty;
  logic        pop = 1'b0;
  logic [2:0]  car_index;
  logic [4:0]  car_floor;
  logic [1:0]  car_dir;
  logic [3:0]  loading;
  logic [3:0]  unloading;
  logic [31:0] dest_bits;
  logic [31:0] up_calls;
  logic [31:0] down_calls;
  logic        last_car;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = CFG_DOOR;
  logic [4:0]  cfg_data = '0;

  elevator_group_dispatch_top dut (.*);

  always #10 clk = ~clk;

  // predictor state
  logic [3:0]  door_ticks;
  logic [4:0]  top_reg;
  logic [31:0] up_map, down_map;
  logic [31:0] car_dest [NCARS];
  logic [4:0]  car_pos [NCARS];
  logic [1:0]  car_hdg [NCARS];
  logic [3:0]  load_left [NCARS];
  logic [3:0]  unload_left [NCARS];

  status_t status_queue [$];
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int errors = 0;
  int cycles = 0;

  function automatic logic [4:0] top_used();
    return (int'(top_reg) > NFLOORS - 1) ? 5'(NFLOORS - 1) : top_reg;
  endfunction

  function automatic logic [31:0] used_mask(logic [4:0] t);
    return (t == 5'd31) ? 32'hFFFF_FFFF : ((32'd1 << (t + 1)) - 32'd1);
  endfunction

  // heading choice and timers for one car within a tick
  function automatic void choose_heading(int c);
    logic [4:0] t;
    logic [31:0] m, dst, calls;
    logic [1:0] h;
    bit da, db, ra, rb, btw_up, btw_dn, opp_up, opp_dn, hi_ok, lo_ok, upl, dnl;
    int cnt_a, cnt_b, near_hi, near_lo, n_up, n_dn, p, f;
    t = top_used();
    m = used_mask(t);
    p = car_pos[c];
    h = car_hdg[c];
    dst = car_dest[c] & m;
    calls = (up_map | down_map) & m;
    {da, db, ra, rb, btw_up, btw_dn, opp_up, opp_dn, hi_ok, lo_ok} = '0;
    cnt_a = 0; cnt_b = 0; near_hi = 0; near_lo = 0; n_up = 0; n_dn = 0;
    if ((car_pos[c] >= t && h == HD_UP) || (p == 0 && h == HD_DOWN)) h = HD_STOP;
    car_hdg[c] = h;
    // unload at a destination
    if (dst[p]) begin
      car_dest[c][p] = 1'b0;
      if (unload_left[c] == 0) unload_left[c] = door_ticks;
      return;
    end
    for (int i = p + 1; i < 32; i++) begin
      if (dst[i]) da = 1;
      if (calls[i]) begin
        ra = 1; cnt_a++;
        if (!hi_ok) begin hi_ok = 1; near_hi = i; end
      end
    end
    for (int i = p - 1; i >= 0; i--) begin
      if (dst[i]) db = 1;
      if (calls[i]) begin
        rb = 1; cnt_b++;
        if (!lo_ok) begin lo_ok = 1; near_lo = i; end
      end
    end
    if (da && h != HD_DOWN) begin car_hdg[c] = HD_UP; return; end
    if (db && h != HD_UP) begin car_hdg[c] = HD_DOWN; return; end
    // board a hall call here
    if ((up_map & m) >> p & 1 && h != HD_DOWN) begin
      car_hdg[c] = HD_UP;
      up_map[p] = 1'b0;
      if (load_left[c] == 0) load_left[c] = door_ticks;
      return;
    end
    if ((down_map & m) >> p & 1 && h != HD_UP) begin
      car_hdg[c] = HD_DOWN;
      down_map[p] = 1'b0;
      if (load_left[c] == 0) load_left[c] = door_ticks;
      return;
    end
    if (!da && !ra && !db && !rb) begin car_hdg[c] = HD_STOP; return; end
    if (h != HD_DOWN && ra) begin car_hdg[c] = HD_UP; return; end
    if (h != HD_DOWN && rb) begin car_hdg[c] = HD_DOWN; return; end
    // weigh the other cars
    for (int i = 0; i < NCARS; i++) begin
      if (i == c) continue;
      f = car_pos[i];
      upl = (car_hdg[i] == HD_UP || car_hdg[i] == HD_STOP);
      dnl = (car_hdg[i] == HD_DOWN || car_hdg[i] == HD_STOP);
      if (upl && ra) begin
        if ((f > p && f <= near_hi) || (f == p && i < c)) btw_up = 1;
        if (f > p || (f == p && i < c)) n_up++;
      end
      if (dnl && rb) begin
        if ((f < p && f >= near_lo) || (f == p && i < c)) btw_dn = 1;
        if (f < p || (f == p && i < c)) n_dn++;
      end
      if (upl && rb && near_lo >= f && near_lo - f < p - near_lo) begin
        opp_up = 1; n_dn++;
      end
      if (dnl && ra && f >= near_hi && f - near_hi < near_hi - p) begin
        opp_dn = 1; n_up++;
      end
    end
    if (h != HD_DOWN && ra && !btw_up && !opp_dn) begin car_hdg[c] = HD_UP; return; end
    if (h != HD_UP && rb && !btw_dn && !opp_up) begin car_hdg[c] = HD_DOWN; return; end
    if (h != HD_DOWN && ra && (btw_up || opp_dn) && n_up < cnt_a) begin
      car_hdg[c] = HD_UP; return;
    end
    if (h != HD_UP && rb && (btw_dn || opp_up) && n_dn < cnt_b) begin
      car_hdg[c] = HD_DOWN; return;
    end
    car_hdg[c] = HD_STOP;
  endfunction

  // apply one accepted command and, for a tick, queue the status record of every car
  function automatic void predict_command(cmd_t cm);
    logic [4:0] t;
    status_t s;
    t = top_used();
    if (cm.mode == MODE_HALL) begin
      if (cm.floor <= t) begin
        if (!cm.hall_dir) up_map[cm.floor] = 1'b1;
        else down_map[cm.floor] = 1'b1;
      end
    end else if (cm.mode == MODE_CAR) begin
      if (cm.car < NCARS && cm.floor <= t && cm.floor != car_pos[cm.car]) begin
        car_dest[cm.car][cm.floor] = 1'b1;
        if (car_hdg[cm.car] == HD_STOP)
          car_hdg[cm.car] = (cm.floor < car_pos[cm.car]) ? HD_DOWN : HD_UP;
      end
    end else if (cm.mode == MODE_TICK) begin
      for (int c = 0; c < NCARS; c++) begin
        if (load_left[c] != 0) load_left[c]--;
        if (unload_left[c] != 0) unload_left[c]--;
        choose_heading(c);
      end
      for (int c = 0; c < NCARS; c++) begin
        if (load_left[c] == 0 && unload_left[c] == 0) begin
          if (car_hdg[c] == HD_UP && car_pos[c] < t) car_pos[c]++;
          else if (car_hdg[c] == HD_DOWN && car_pos[c] > 0) car_pos[c]--;
        end
      end
      for (int c = 0; c < NCARS; c++) begin
        s.car_index = 3'(c);
        s.car_floor = car_pos[c];
        s.car_dir = car_hdg[c];
        s.loading = load_left[c];
        s.unloading = unload_left[c];
        s.dest_bits = car_dest[c];
        s.up_calls = up_map;
        s.down_calls = down_map;
        s.last_car = (c == NCARS - 1);
        status_queue.push_back(s);
      end
    end
  endfunction

  // drive one command and wait for its transfer; push stays high for a following command
  task automatic send_cmd(logic [1:0] md, logic [4:0] fl, logic hd, logic [2:0] cr);
    cmd_t cm;
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    cm = '{mode: md, floor: fl, hall_dir: hd, car: cr};
    push <= 1'b1;
    mode <= md;
    floor <= fl;
    hall_dir <= hd;
    car <= cr;
    do @(posedge clk); while (full);
    predict_command(cm);
  endtask

  task automatic tick();
    send_cmd(MODE_TICK, 5'($urandom), 1'($urandom), 3'($urandom));
  endtask

  task automatic drain();
    push <= 1'b0;
    while (status_queue.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  // register write while idle
  task automatic write_reg(logic [1:0] idx, logic [4:0] val);
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_DOOR) door_ticks = val[3:0];
    else top_reg = val;
  endtask

  // status checker
  always @(posedge clk) begin
    status_t exp_s, got;
    if (!rst) begin
      if (pop && !empty) begin
        got = '{car_index, car_floor, car_dir, loading, unloading, dest_bits,
                up_calls, down_calls, last_car};
        if (status_queue.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected status transfer: %p", got);
        end else begin
          exp_s = status_queue.pop_front();
          if (got !== exp_s) begin
            errors++;
            if (errors <= 10) $display("status mismatch: expected %p, got %p", exp_s, got);
          end
        end
      end
      pop <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > MAX_CYCLES) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic test_directed();
    // calls above the top, unused mode, bad car, own floor
    send_cmd(MODE_HALL, 5'd31, 1'b0, 3'd0);
    send_cmd(MODE_HALL, 5'd19, 1'b1, 3'd0);
    send_cmd(MODE_HALL, 5'd0, 1'b0, 3'd0);
    send_cmd(2'd3, 5'd5, 1'b1, 3'd7);
    send_cmd(MODE_CAR, 5'd0, 1'b0, 3'd1);
    send_cmd(MODE_CAR, 5'd10, 1'b0, 3'd7);
    send_cmd(MODE_CAR, 5'd25, 1'b0, 3'd2);
    send_cmd(MODE_CAR, 5'd7, 1'b1, 3'd3);
    send_cmd(MODE_HALL, 5'd12, 1'b1, 3'd0);
    repeat (12) tick();
    send_cmd(MODE_CAR, 5'd0, 1'b0, 3'd3);
    repeat (6) tick();
  endtask

  task automatic test_random(int n);
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < 45) tick();
      else if (r < 70) send_cmd(MODE_HALL, 5'($urandom_range(top_reg)), 1'($urandom),
                                3'($urandom));
      else if (r < 95) send_cmd(MODE_CAR, 5'($urandom_range(top_reg)), 1'($urandom),
                                3'($urandom_range(NCARS - 1)));
      else send_cmd(2'($urandom), 5'($urandom), 1'($urandom), 3'($urandom));
    end
  endtask

  task automatic test_config_sweep();
    write_reg(CFG_DOOR, 5'd0);
    write_reg(CFG_TOP, 5'd31);
    send_idle_pct = 82; recv_stall_pct = 0;
    test_random(40);
    write_reg(CFG_DOOR, 5'd15);
    write_reg(CFG_TOP, 5'd1);
    send_idle_pct = 0; recv_stall_pct = 82;
    test_random(40);
    write_reg(CFG_DOOR, 5'd1);
    write_reg(CFG_TOP, 5'd9);
    send_idle_pct = 7; recv_stall_pct = 7;
    test_random(50);
    write_reg(CFG_DOOR, 5'd3);
    write_reg(CFG_TOP, 5'd19);
    send_idle_pct = 0; recv_stall_pct = 0;
    test_random(50);
  endtask

  initial begin
    door_ticks = DOOR_RESET;
    top_reg = TOP_RESET;
    up_map = '0;
    down_map = '0;
    for (int c = 0; c < NCARS; c++) begin
      car_dest[c] = '0; car_pos[c] = '0; car_hdg[c] = HD_STOP;
      load_left[c] = '0; unload_left[c] = '0;
    end
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_config_sweep();
    drain();
    if (errors == 0 && status_queue.size() == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule
